FILE: design/qev_pkg.sv
// Shared types, constants and helpers for the quadrature encoder velocity block.
// Used by the top level and the testbench; depends on nothing.
package qev_pkg;

  localparam int CHANNELS    = 4;
  localparam int COUNT_WIDTH = 32;
  localparam int MAX_RESULTS = 4;
  localparam int TICK_RESULTS = (CHANNELS < MAX_RESULTS) ? CHANNELS : MAX_RESULTS;
  localparam int CH_AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SCALE_WIDTH = 24;
  localparam int PROD_WIDTH  = COUNT_WIDTH + SCALE_WIDTH + 1;
  localparam int VEL_SHIFT   = 8;

  localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = SCALE_WIDTH'(128108);

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TK_RD,
    ST_TK_DELTA,
    ST_TK_MUL,
    ST_TK_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]             levels;
    logic [COUNT_WIDTH-1:0] count;
    logic [COUNT_WIDTH-1:0] snap;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{levels: 2'b11, count: '0, snap: '0};

  // index is {previous A, previous B, current A, current B}
  localparam logic [1:0] STEP_TABLE [16] = '{
    2'b00, 2'b11, 2'b01, 2'b00, 2'b01, 2'b00, 2'b00, 2'b11,
    2'b11, 2'b00, 2'b00, 2'b01, 2'b00, 2'b01, 2'b11, 2'b00
  };

  function automatic logic [31:0] sext32(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+31:0] w;
    w = {{32{v[COUNT_WIDTH-1]}}, v};
    return w[31:0];
  endfunction

endpackage

FILE: design/qev_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module qev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/quadrature_encoder_velocity.sv
// Top level of the multi-channel x4 quadrature decoder with per-period velocity.
// Depends on qev_pkg and qev_ram.
//
// Pin samples are taken one word per clock while no tick walk runs and the output is not stalled:
// each sample reads its channel's entry from the state RAM, and once the output register
// is free the updated entry is written back and the result word is loaded into that register; a
// sample on the channel just written gets the fresh entry through a bypass register.
// A tick word walks all channels through the same state RAM (read, delta and snapshot
// write-back, multiply, saturate for each), holding the input until the walk is done.
// Reset needs no clearing pass: per-channel valid bits make unwritten entries read as
// levels 3, position 0, snapshot 0.
module quadrature_encoder_velocity (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [0] level_a, [1] level_b
  input  logic [2:0]  in_tuser,      // [0] cmd, [2:1] channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,     // [31:0] position, [63:32] delta, [95:64] velocity
  output logic [1:0]  out_tuser,     // [1:0] chan_out
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data    // velocity_scale
);
  import qev_pkg::*;

  state_t                  state_r, state_nxt;
  logic [CH_AW-1:0]        idx_r, idx_nxt;
  logic [SCALE_WIDTH-1:0]  scale_r;

  logic                    s1_vld_r;
  logic [CH_AW-1:0]        s1_addr_r;
  logic [1:0]              s1_cur_r;

  logic                    fwd_vld_r;
  logic [CH_AW-1:0]        fwd_addr_r;
  entry_t                  fwd_data_r;
  logic [CHANNELS-1:0]     entry_vld_r;

  logic [COUNT_WIDTH-1:0]  tk_pos_r;
  logic [COUNT_WIDTH-1:0]  tk_delta_r;
  logic signed [PROD_WIDTH-1:0] prod_r;

  logic                    out_vld_r;
  logic [1:0]              out_chan_r;
  logic [31:0]             out_pos_r, out_delta_r, out_vel_r;
  logic                    out_last_r;

  logic                    cmd, ch_ok, in_acc, smp_acc, tick_acc;
  logic [1:0]              channel;
  logic                    out_free, s1_go, tk_emit, tk_load;
  logic [CH_AW-1:0]        cur_addr;
  entry_t                  ram_rdata, ent, wr_data;
  logic                    ram_we, ram_re;
  logic [CH_AW-1:0]        ram_waddr, ram_raddr;
  logic [1:0]              step;
  logic [COUNT_WIDTH-1:0]  smp_count, tk_delta;
  logic [PROD_WIDTH-1:VEL_SHIFT+31] prod_hi;
  logic [31:0]             vel_sat;

  assign cmd      = in_tuser[0];
  assign channel  = in_tuser[2:1];
  assign ch_ok    = {1'b0, channel} < 3'(CHANNELS > 7 ? 7 : CHANNELS)
                    || CHANNELS > 4;
  assign out_free = !out_vld_r || out_tready;
  assign s1_go    = s1_vld_r && out_free;
  assign in_tready = (state_r == ST_IDLE) && (!s1_vld_r || s1_go);
  assign in_acc   = in_tvalid && in_tready;
  assign smp_acc  = in_acc && (cmd == CMD_SAMPLE) && ch_ok;
  assign tick_acc = in_acc && (cmd == CMD_TICK);

  assign cur_addr = (state_r == ST_TK_DELTA) ? idx_r : s1_addr_r;

  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == cur_addr)) begin
      ent = fwd_data_r;
    end else if (entry_vld_r[cur_addr]) begin
      ent = ram_rdata;
    end else begin
      ent = ENTRY_RESET;
    end
  end

  assign step      = STEP_TABLE[{ent.levels, s1_cur_r}];
  assign smp_count = ent.count + {{(COUNT_WIDTH-2){step[1]}}, step};
  assign tk_delta  = ent.count - ent.snap;

  always_comb begin
    if (state_r == ST_TK_DELTA) begin
      wr_data = '{levels: ent.levels, count: ent.count, snap: ent.count};
    end else begin
      wr_data = '{levels: s1_cur_r, count: smp_count, snap: ent.snap};
    end
  end

  assign ram_we    = s1_go || (state_r == ST_TK_DELTA);
  assign ram_waddr = cur_addr;
  assign ram_re    = smp_acc || (state_r == ST_TK_RD);
  assign ram_raddr = (state_r == ST_TK_RD) ? idx_r : CH_AW'(channel);

  qev_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign prod_hi = prod_r[PROD_WIDTH-1:VEL_SHIFT+31];
  always_comb begin
    if ((&prod_hi) || !(|prod_hi)) begin
      vel_sat = prod_r[VEL_SHIFT+31:VEL_SHIFT];
    end else if (prod_r[PROD_WIDTH-1]) begin
      vel_sat = 32'h8000_0000;
    end else begin
      vel_sat = 32'h7FFF_FFFF;
    end
  end

  assign tk_emit = {1'b0, idx_r} < (CH_AW+1)'(TICK_RESULTS);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    tk_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (tick_acc) begin
          state_nxt = ST_TK_RD;
          idx_nxt   = '0;
        end
      end
      ST_TK_RD:    state_nxt = ST_TK_DELTA;
      ST_TK_DELTA: state_nxt = ST_TK_MUL;
      ST_TK_MUL:   state_nxt = ST_TK_OUT;
      ST_TK_OUT: begin
        if (!tk_emit || out_free) begin
          tk_load = tk_emit;
          if (idx_r == CH_AW'(CHANNELS-1)) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_TK_RD;
            idx_nxt   = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      scale_r     <= SCALE_RESET;
      s1_vld_r    <= 1'b0;
      fwd_vld_r   <= 1'b0;
      entry_vld_r <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      if (cfg_wr_en) begin
        scale_r <= cfg_wr_data;
      end
      if (smp_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
      if (ram_we) begin
        fwd_vld_r              <= 1'b1;
        entry_vld_r[ram_waddr] <= 1'b1;
      end
      if (s1_go || tk_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_acc) begin
      s1_addr_r <= CH_AW'(channel);
      s1_cur_r  <= {in_tdata[0], in_tdata[1]};
    end
    if (ram_we) begin
      fwd_addr_r <= ram_waddr;
      fwd_data_r <= wr_data;
    end
    if (state_r == ST_TK_DELTA) begin
      tk_pos_r   <= ent.count;
      tk_delta_r <= tk_delta;
    end
    if (state_r == ST_TK_MUL) begin
      prod_r <= $signed(tk_delta_r) * $signed({1'b0, scale_r});
    end
    if (s1_go) begin
      out_chan_r  <= 2'(s1_addr_r);
      out_pos_r   <= sext32(smp_count);
      out_delta_r <= {{30{step[1]}}, step};
      out_vel_r   <= '0;
      out_last_r  <= 1'b1;
    end else if (tk_load) begin
      out_chan_r  <= 2'(idx_r);
      out_pos_r   <= sext32(tk_pos_r);
      out_delta_r <= sext32(tk_delta_r);
      out_vel_r   <= vel_sat;
      out_last_r  <= (idx_r == CH_AW'(TICK_RESULTS-1));
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_vel_r, out_delta_r, out_pos_r};
  assign out_tuser  = out_chan_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_s1_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> (state_r == ST_IDLE))
    else $error("sample in flight during tick walk");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_go && (state_r == ST_TK_DELTA)))
    else $error("two writers on state RAM");

  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> (state_r == ST_TK_RD) && (idx_r == '0))
    else $error("tick did not start channel walk");

  a_inner_result_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_last_r) |-> (state_r != ST_IDLE))
    else $error("non-final result outside tick walk");
`endif

endmodule

FILE: test/quadrature_encoder_velocity_test.sv
// Self-checking testbench for quadrature_encoder_velocity: directed table, then random
// gray-code walks, period ticks and a short one-channel sweep, all checked word by word.
// Depends on qev_pkg and the quadrature_encoder_velocity RTL.
`timescale 1ns / 1ps

module quadrature_encoder_velocity_test;
  import qev_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_WORDS = 104;
  localparam int SWEEP_STEPS = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 24;
  localparam int PRINT_CAP = 50;
  localparam logic [23:0] SCALE_MAX = 24'hFF_FFFF;
  localparam longint VEL_MAX = 64'sd2147483647;
  localparam longint VEL_MIN = -64'sd2147483648;

  typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

  typedef struct {
    logic [1:0]  chan;
    logic [31:0] position;
    logic [31:0] delta;
    logic [31:0] velocity;
    logic        last;
  } encoder_result_t;

  typedef struct {
    logic        cmd;
    logic [1:0]  chan;
    logic        a;
    logic        b;
    bit          typed;
    logic [31:0] position;
    logic [31:0] step;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [0] level_a, [1] level_b
  logic [2:0]  in_tuser = '0;     // [0] cmd, [2:1] channel
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;         // [31:0] position, [63:32] delta, [95:64] velocity
  logic [1:0]  out_tuser;         // [1:0] chan_out
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [23:0] cfg_wr_data = '0;  // velocity_scale

  quadrature_encoder_velocity dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // encoder state as the block should hold it
  logic [1:0]  enc_levels [CHANNELS];
  logic [31:0] enc_count [CHANNELS];
  logic [31:0] enc_snapshot [CHANNELS];
  logic [23:0] scale_now = SCALE_RESET;
  bit          heading [CHANNELS];

  encoder_result_t results_due [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  pace_t       pace = PACE_FULL;
  int          holds_wanted = 0;
  int          holds_served = 0;
  int          hold_left = 0;

  directed_row_t directed_rows [20] = '{
    '{CMD_SAMPLE, 2'd0, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0},
    '{CMD_TICK,   2'd0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CMD_SAMPLE, 2'd0, 1'b0, 1'b1, 1'b1, 32'd1, 32'd1},
    '{CMD_SAMPLE, 2'd0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CMD_SAMPLE, 2'd0, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CMD_SAMPLE, 2'd0, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
    '{CMD_SAMPLE, 2'd1, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{CMD_SAMPLE, 2'd1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CMD_SAMPLE, 2'd2, 1'b0, 1'b0, 1'b1, 32'd0, 32'd0},
    '{CMD_SAMPLE, 2'd2, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
    '{CMD_SAMPLE, 2'd3, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
    '{CMD_TICK,   2'd3, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
    '{CMD_SAMPLE, 2'd3, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0},
    '{CMD_SAMPLE, 2'd3, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CMD_SAMPLE, 2'd1, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0},
    '{CMD_SAMPLE, 2'd1, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0},
    '{CMD_TICK,   2'd2, 1'b0, 1'b1, 1'b0, 32'd0, 32'd0},
    '{CMD_TICK,   2'd1, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CMD_SAMPLE, 2'd2, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0},
    '{CMD_TICK,   2'd0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}
  };

  function automatic int quad_step(logic [1:0] prev, logic [1:0] cur);
    case ({prev, cur})
      4'b1101, 4'b0100, 4'b0010, 4'b1011: return 1;
      4'b0001, 4'b0111, 4'b1000, 4'b1110: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic logic [1:0] next_levels(logic [1:0] lv, bit forward);
    case (lv)
      2'b11: return forward ? 2'b01 : 2'b10;
      2'b01: return forward ? 2'b00 : 2'b11;
      2'b00: return forward ? 2'b10 : 2'b01;
      default: return forward ? 2'b11 : 2'b00;
    endcase
  endfunction

  function automatic logic [31:0] scaled_velocity(logic [31:0] counts, logic [23:0] scale);
    longint product;
    longint shifted;
    product = longint'($signed(counts)) * longint'(scale);
    shifted = product >>> 8;
    if (shifted > VEL_MAX) return 32'h7FFF_FFFF;
    if (shifted < VEL_MIN) return 32'h8000_0000;
    return shifted[31:0];
  endfunction

  task automatic decode_word(logic cmd, logic [1:0] ch, logic a, logic b);
    encoder_result_t r;
    int st;
    logic [31:0] d;
    if (cmd == CMD_SAMPLE) begin
      st = quad_step(enc_levels[ch], {a, b});
      enc_levels[ch] = {a, b};
      enc_count[ch] = enc_count[ch] + 32'(st);
      r = '{ch, enc_count[ch], 32'(st), 32'd0, 1'b1};
      results_due.push_back(r);
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        d = enc_count[i] - enc_snapshot[i];
        r = '{2'(i), enc_count[i], d, scaled_velocity(d, scale_now), i == CHANNELS - 1};
        results_due.push_back(r);
        enc_snapshot[i] = enc_count[i];
      end
    end
  endtask

  function automatic bit sender_rests();
    if (pace == PACE_SEND_IDLE) return $urandom_range(99) < 81;
    if (pace == PACE_BOTH) return $urandom_range(99) < 12;
    return 1'b0;
  endfunction

  task automatic send_word(logic cmd, logic [1:0] ch, logic a, logic b);
    while (sender_rests()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, b, a};
    in_tuser <= {ch, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_word(cmd, ch, a, b);
  endtask

  task automatic send_random_word();
    int roll;
    logic [1:0] ch;
    logic [1:0] lv;
    roll = $urandom_range(99);
    ch = 2'($urandom_range(3));
    if (roll < 7) begin
      send_word(CMD_TICK, ch, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end else begin
      if ($urandom_range(9) == 0) heading[ch] = !heading[ch];
      if (roll < 75) lv = next_levels(enc_levels[ch], heading[ch]);
      else if (roll < 87) lv = enc_levels[ch];
      else lv = 2'($urandom_range(3));
      send_word(CMD_SAMPLE, ch, lv[1], lv[0]);
    end
  endtask

  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(logic [23:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scale_now = value;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("quadrature_encoder_velocity_test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (holds_served != holds_wanted) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (pace == PACE_RECV_STALL) begin
      out_tready <= $urandom_range(99) >= 81;
    end else if (pace == PACE_BOTH) begin
      out_tready <= $urandom_range(99) >= 12;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    encoder_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("word with nothing due, position", out_tdata[31:0], 32'd0);
      end else begin
        want = results_due.pop_front();
        if (out_tuser !== want.chan)
          report_mismatch("chan_out", 32'(out_tuser), 32'(want.chan));
        if (out_tdata[31:0] !== want.position)
          report_mismatch("position", out_tdata[31:0], want.position);
        if (out_tdata[63:32] !== want.delta)
          report_mismatch("delta", out_tdata[63:32], want.delta);
        if (out_tdata[95:64] !== want.velocity)
          report_mismatch("velocity", out_tdata[95:64], want.velocity);
        if (out_tlast !== want.last)
          report_mismatch("last", 32'(out_tlast), 32'(want.last));
      end
    end
  end

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      enc_levels[i] = 2'b11;
      enc_count[i] = '0;
      enc_snapshot[i] = '0;
      heading[i] = 1'($urandom_range(1));
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].cmd, directed_rows[i].chan, directed_rows[i].a,
                directed_rows[i].b);
      if (directed_rows[i].typed)
        results_due[results_due.size() - 1] = '{directed_rows[i].chan,
            directed_rows[i].position, directed_rows[i].step, 32'd0, 1'b1};
    end
    settle_block();

    // full rate, one long output hold, one mid-phase drain
    write_scale(24'($urandom_range(SCALE_MAX)));
    pace = PACE_FULL;
    holds_wanted = holds_wanted + 1;
    for (int n = 0; n < PHASE_WORDS; n++) begin
      send_random_word();
      if (n == PHASE_WORDS / 2) settle_block();
    end
    settle_block();

    write_scale(24'd0);
    pace = PACE_SEND_IDLE;
    repeat (PHASE_WORDS) send_random_word();
    settle_block();

    write_scale(SCALE_MAX);
    pace = PACE_RECV_STALL;
    repeat (PHASE_WORDS) send_random_word();
    settle_block();

    write_scale(24'($urandom_range(SCALE_MAX)));
    pace = PACE_BOTH;
    repeat (PHASE_WORDS) send_random_word();
    settle_block();

    // sweep one channel forward, then back past its start, at full scale
    write_scale(SCALE_MAX);
    pace = PACE_FULL;
    send_word(CMD_TICK, 2'd0, 1'b0, 1'b0);
    repeat (SWEEP_STEPS) begin
      logic [1:0] lv;
      lv = next_levels(enc_levels[0], 1'b1);
      send_word(CMD_SAMPLE, 2'd0, lv[1], lv[0]);
    end
    send_word(CMD_TICK, 2'd1, 1'b1, 1'b1);
    repeat (2 * SWEEP_STEPS) begin
      logic [1:0] lv;
      lv = next_levels(enc_levels[0], 1'b0);
      send_word(CMD_SAMPLE, 2'd0, lv[1], lv[0]);
    end
    send_word(CMD_TICK, 2'd3, 1'b0, 1'b1);
    settle_block();

    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("quadrature_encoder_velocity_test passed");
    end else begin
      $display("quadrature_encoder_velocity_test failed");
    end
    $finish;
  end

endmodule
